/* rtl/windowed_frame_averager_macros.svh */
// Assertion helpers for the frame averager.
`ifndef WINDOWED_FRAME_AVERAGER_MACROS_SVH
`define WINDOWED_FRAME_AVERAGER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WFA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame averager check failed");
`define WFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame averager check failed");
`else
`define WFA_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define WFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/wfa_pkg.sv */
`timescale 1ns / 1ps
package wfa_pkg;

  localparam logic [2:0] ACT_SKIP        = 3'd0;
  localparam logic [2:0] ACT_START       = 3'd1;
  localparam logic [2:0] ACT_ACC         = 3'd2;
  localparam logic [2:0] ACT_CLOSE_START = 3'd3;
  localparam logic [2:0] ACT_CLOSE_SKIP  = 3'd4;

  localparam logic [2:0] KIND_VIS  = 3'd0;
  localparam logic [2:0] KIND_EVAL = 3'd1;
  localparam logic [2:0] KIND_EVEC = 3'd2;
  localparam logic [2:0] KIND_ERMS = 3'd3;
  localparam logic [2:0] KIND_TOT  = 3'd4;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_RE   = 3'd1;
  localparam logic [2:0] OP_IM   = 3'd2;
  localparam logic [2:0] OP_CW   = 3'd3;
  localparam logic [2:0] OP_INV  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 8'd1;

  localparam logic [8:0]  NS_RESET  = 9'd2;
  localparam logic [31:0] AGE_RESET = 32'd120000;
  localparam logic [8:0]  FIW_MAX   = 9'd511;

  localparam int DIV_W = 64;

  typedef struct packed {
    logic       load;
    logic       decide;
    logic       chan_err;
    logic       div_start;
    logic [2:0] op;
    logic       div_latch;
    logic       rd;
    logic       emit;
    logic       write;
  } wfa_cmd_t;

  typedef struct packed {
    logic       first;
    logic       locked;
    logic       ch_mis;
    logic [2:0] act;
    logic       item_ok;
    logic [2:0] kind;
    logic       div_done;
    logic       div_busy;
    logic       out_free;
  } wfa_sts_t;

  function automatic logic [2:0] next_op(input logic [2:0] cur, input logic [2:0] kind,
                                         input logic closing, input logic update);
    logic need_re;
    logic need_im;
    logic need_cw;
    logic need_inv;
    logic [2:0] res;
    need_re  = closing && (kind == KIND_VIS || kind == KIND_EVAL ||
                           kind == KIND_EVEC || kind == KIND_ERMS);
    need_im  = closing && (kind == KIND_VIS || kind == KIND_EVEC);
    need_cw  = closing && (kind == KIND_VIS);
    need_inv = update && (kind == KIND_VIS);
    res = OP_NONE;
    if (cur < OP_RE && need_re) begin
      res = OP_RE;
    end else if (cur < OP_IM && need_im) begin
      res = OP_IM;
    end else if (cur < OP_CW && need_cw) begin
      res = OP_CW;
    end else if (cur < OP_INV && need_inv) begin
      res = OP_INV;
    end
    return res;
  endfunction

endpackage

/* rtl/wfa_if.sv */
`timescale 1ns / 1ps
interface wfa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [12:0]        index;
  logic               first_item;
  logic               last_item;
  logic [63:0]        seq_start;
  logic [31:0]        seq_length;
  logic [15:0]        channel_id;
  logic [63:0]        time_ms;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic [31:0]        weight;
  modport source (output valid, kind, index, first_item, last_item, seq_start, seq_length,
                  channel_id, time_ms, value_re, value_im, weight, input ready);
  modport sink (input valid, kind, index, first_item, last_item, seq_start, seq_length,
                channel_id, time_ms, value_re, value_im, weight, output ready);
endinterface

interface wfa_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_kind;
  logic [12:0]        out_index;
  logic signed [31:0] avg_re;
  logic signed [31:0] avg_im;
  logic [31:0]        avg_weight;
  logic [63:0]        window_start;
  logic [63:0]        window_len;
  logic               out_last;
  logic               channel_error;
  modport source (output valid, out_kind, out_index, avg_re, avg_im, avg_weight,
                  window_start, window_len, out_last, channel_error, input ready);
  modport sink (input valid, out_kind, out_index, avg_re, avg_im, avg_weight,
                window_start, window_len, out_last, channel_error, output ready);
endinterface

interface wfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  idx;
  logic [31:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

/* rtl/wfa_ram.sv */
`timescale 1ns / 1ps
module wfa_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic                                   re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [W-1:0]                           rdata_r
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

/* rtl/wfa_div.sv */
`timescale 1ns / 1ps
module wfa_div import wfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [DIV_W-1:0] rem
);
  localparam int CW = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   sh;
  logic             ge;

  assign sh = {rem_r, quo_r[DIV_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_W'(sh - {1'b0, den_r}) : sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

/* rtl/wfa_dp.sv */
`timescale 1ns / 1ps
module wfa_dp import wfa_pkg::*; #(
  parameter int N_PRODUCTS = 4096,
  parameter int NUM_ELEM = 2048,
  parameter int NUM_EV = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  wfa_in_if.sink   in_ch,
  wfa_out_if.source out_ch,
  wfa_cfg_if.sink  cfg_ch,
  input  wfa_cmd_t cmd,
  output wfa_sts_t sts
);
  localparam int EIG_DEPTH = NUM_EV + NUM_EV * NUM_ELEM + 1;
  localparam int VIS_AW = $clog2(N_PRODUCTS > 1 ? N_PRODUCTS : 2);
  localparam int EIG_AW = $clog2(EIG_DEPTH > 1 ? EIG_DEPTH : 2);

  function automatic logic [31:0] sat32(input logic signed [41:0] x);
    if (x > 42'sd2147483647) return 32'h7fff_ffff;
    if (x < -42'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [39:0] sat40(input logic signed [40:0] x);
    if (x[40] != x[39]) return x[40] ? 40'h80_0000_0000 : 40'h7f_ffff_ffff;
    return x[39:0];
  endfunction

  function automatic logic [39:0] mag40(input logic [39:0] x);
    return x[39] ? 40'(~x + 40'd1) : x;
  endfunction

  // item
  logic [2:0]  kind_r;
  logic [12:0] idx_r;
  logic        first_r;
  logic        last_r;
  logic [63:0] sstart_r;
  logic [31:0] slen_r;
  logic [15:0] ch_r;
  logic [63:0] tms_r;
  logic [31:0] re_r;
  logic [31:0] im_r;
  logic [31:0] w_r;
  logic [40:0] wl_r;

  // config and window state
  logic [8:0]  ns_r;
  logic [31:0] max_age_r;
  logic        locked_r;
  logic [15:0] lock_ch_r;
  logic [63:0] lock_len_r;
  logic [8:0]  fiw_r;
  logic [63:0] win_end_r;
  logic [63:0] win_begin_r;
  logic [63:0] win_time_r;
  logic [63:0] win_len_r;
  logic [2:0]  act_r;
  logic [8:0]  close_n_r;
  logic [17:0] nsq_r;
  logic [63:0] close_begin_r;
  logic [63:0] close_len_r;
  logic [39:0] tot_re_r;
  logic [39:0] tot_im_r;

  // results
  logic [31:0] res_re_r;
  logic [31:0] res_im_r;
  logic [31:0] res_w_r;
  logic [31:0] inv_r;

  // output register
  logic        out_valid_r;
  logic [2:0]  o_kind_r;
  logic [12:0] o_idx_r;
  logic [31:0] o_re_r;
  logic [31:0] o_im_r;
  logic [31:0] o_w_r;
  logic [63:0] o_start_r;
  logic [63:0] o_len_r;
  logic        o_last_r;
  logic        o_cherr_r;

  // divider
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] q;
  logic [DIV_W-1:0] r;
  logic             div_busy;
  logic             div_done;
  logic [2:0]       run_op_r;

  // memories
  logic [79:0]       vis_rd;
  logic [47:0]       var_rd;
  logic [79:0]       eig_rd;
  logic [79:0]       vis_wd;
  logic [47:0]       var_wd;
  logic [79:0]       eig_wd;
  logic [VIS_AW-1:0] vis_slot;
  logic [EIG_AW-1:0] eig_slot;
  logic              item_ok;
  logic              we_vis;
  logic              we_eig;

  // arithmetic helpers
  logic [39:0]        src_re;
  logic [39:0]        src_im;
  logic               neg;
  logic signed [41:0] qs;
  logic signed [41:0] qsig;
  logic               acc;
  logic [48:0]        var_sum;

  // frame decision
  logic        lock_ok;
  logic        pos0;
  logic [63:0] eff_len;
  logic [2:0]  act_n;
  logic [8:0]  fiw_n;
  logic        closes;
  logic        starts;
  logic        out_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_ch.kind;
      idx_r    <= in_ch.index;
      first_r  <= in_ch.first_item;
      last_r   <= in_ch.last_item;
      sstart_r <= in_ch.seq_start;
      slen_r   <= in_ch.seq_length;
      ch_r     <= in_ch.channel_id;
      tms_r    <= in_ch.time_ms;
      re_r     <= in_ch.value_re;
      im_r     <= in_ch.value_im;
      w_r      <= in_ch.weight;
      wl_r     <= 41'(ns_r) * 41'(in_ch.seq_length);
    end
  end

  always_comb begin
    item_ok  = 1'b0;
    vis_slot = VIS_AW'(idx_r);
    eig_slot = EIG_AW'(EIG_DEPTH - 1);
    case (kind_r)
      KIND_VIS: item_ok = 32'(idx_r) < N_PRODUCTS;
      KIND_EVAL: begin
        item_ok  = 32'(idx_r) < NUM_EV;
        eig_slot = EIG_AW'(idx_r);
      end
      KIND_EVEC: begin
        item_ok  = 32'(idx_r) < NUM_EV * NUM_ELEM;
        eig_slot = EIG_AW'(32'(NUM_EV) + 32'(idx_r));
      end
      KIND_ERMS, KIND_TOT: item_ok = 1'b1;
      default: item_ok = 1'b0;
    endcase
  end

  assign src_re = (kind_r == KIND_VIS) ? vis_rd[79:40] : eig_rd[79:40];
  assign src_im = (kind_r == KIND_VIS) ? vis_rd[39:0] : eig_rd[39:0];
  assign eff_len = locked_r ? lock_len_r : 64'(wl_r);

  always_comb begin
    dvd = '0;
    dvs = '0;
    unique case (cmd.op)
      OP_MOD: begin
        dvd = sstart_r;
        dvs = eff_len;
      end
      OP_RE: begin
        dvd = 64'(mag40(src_re));
        dvs = 64'(close_n_r);
      end
      OP_IM: begin
        dvd = 64'(mag40(src_im));
        dvs = 64'(close_n_r);
      end
      OP_CW: begin
        dvd = {14'd0, nsq_r, 32'd0};
        dvs = 64'(var_rd);
      end
      OP_INV: begin
        dvd = 64'h1_0000_0000;
        dvs = 64'(w_r);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  wfa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dvd), .divisor(dvs),
    .busy(div_busy), .done(div_done), .quo(q), .rem(r)
  );

  // op of the divide in flight
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      run_op_r <= cmd.op;
    end
  end

  assign neg  = (run_op_r == OP_IM) ? src_im[39] : src_re[39];
  assign qs   = {1'b0, q[40:0]};
  assign qsig = neg ? -qs : qs;

  always_ff @(posedge clk) begin
    if (cmd.div_latch) begin
      unique case (run_op_r)
        OP_RE: res_re_r <= (close_n_r == '0) ? 32'd0 : sat32(qsig);
        OP_IM: res_im_r <= (close_n_r == '0) ? 32'd0 : sat32(qsig);
        OP_CW: res_w_r <= (q[63:32] != '0) ? 32'hffff_ffff : q[31:0];
        OP_INV: inv_r <= (q[63:32] != '0) ? 32'hffff_ffff : q[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lock_ok = locked_r || (r == '0);
    pos0    = r < 64'(slen_r);
    act_n   = ACT_SKIP;
    fiw_n   = fiw_r;
    closes  = 1'b0;
    if (!lock_ok) begin
      act_n = ACT_SKIP;
    end else if (fiw_r == '0) begin
      act_n = pos0 ? ACT_START : ACT_SKIP;
    end else if (sstart_r < win_end_r) begin
      act_n = ACT_ACC;
      fiw_n = (fiw_r == FIW_MAX) ? fiw_r : fiw_r + 9'd1;
    end else if (tms_r > win_time_r && (tms_r - win_time_r) > 64'(max_age_r)) begin
      fiw_n = '0;
      act_n = pos0 ? ACT_START : ACT_SKIP;
    end else begin
      closes = 1'b1;
      fiw_n  = '0;
      act_n  = pos0 ? ACT_CLOSE_START : ACT_CLOSE_SKIP;
    end
    starts = act_n == ACT_START || act_n == ACT_CLOSE_START;
    if (starts) begin
      fiw_n = 9'd1;
    end
  end

  assign acc     = act_r == ACT_ACC;
  assign var_sum = 49'(inv_r) + 49'(var_rd);
  assign vis_wd  = {acc ? sat40(41'($signed(vis_rd[79:40])) + 41'($signed(re_r)))
                        : 40'($signed(re_r)),
                    acc ? sat40(41'($signed(vis_rd[39:0])) + 41'($signed(im_r)))
                        : 40'($signed(im_r))};
  assign var_wd  = acc ? (var_sum[48] ? 48'hffff_ffff_ffff : var_sum[47:0]) : 48'(inv_r);
  assign eig_wd  = {acc ? sat40(41'($signed(eig_rd[79:40])) + 41'($signed(re_r)))
                        : 40'($signed(re_r)),
                    acc ? sat40(41'($signed(eig_rd[39:0])) + 41'($signed(im_r)))
                        : 40'($signed(im_r))};
  assign we_vis  = cmd.write && kind_r == KIND_VIS;
  assign we_eig  = cmd.write && kind_r != KIND_VIS && kind_r != KIND_TOT;

  wfa_ram #(.W(80), .DEPTH(N_PRODUCTS)) u_vis (
    .clk(clk), .we(we_vis), .waddr(vis_slot), .wdata(vis_wd),
    .re(cmd.rd), .raddr(vis_slot), .rdata_r(vis_rd)
  );

  wfa_ram #(.W(48), .DEPTH(N_PRODUCTS)) u_var (
    .clk(clk), .we(we_vis), .waddr(vis_slot), .wdata(var_wd),
    .re(cmd.rd), .raddr(vis_slot), .rdata_r(var_rd)
  );

  wfa_ram #(.W(80), .DEPTH(EIG_DEPTH)) u_eig (
    .clk(clk), .we(we_eig), .waddr(eig_slot), .wdata(eig_wd),
    .re(cmd.rd), .raddr(eig_slot), .rdata_r(eig_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r          <= NS_RESET;
      max_age_r     <= AGE_RESET;
      locked_r      <= 1'b0;
      lock_ch_r     <= '0;
      lock_len_r    <= '0;
      fiw_r         <= '0;
      win_end_r     <= '0;
      win_begin_r   <= '0;
      win_time_r    <= '0;
      win_len_r     <= '0;
      act_r         <= ACT_SKIP;
      close_n_r     <= '0;
      nsq_r         <= '0;
      close_begin_r <= '0;
      close_len_r   <= '0;
      tot_re_r      <= '0;
      tot_im_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.idx)
          REG_NUM_SAMPLES: ns_r <= cfg_ch.data[8:0];
          REG_MAX_AGE: max_age_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (cmd.decide) begin
        act_r <= act_n;
        if (lock_ok) begin
          fiw_r <= fiw_n;
          if (!locked_r) begin
            locked_r   <= 1'b1;
            lock_ch_r  <= ch_r;
            lock_len_r <= 64'(wl_r);
          end
          if (!locked_r || starts) begin
            win_end_r <= sstart_r + eff_len;
          end
          if (closes) begin
            close_n_r     <= fiw_r;
            nsq_r         <= 18'(fiw_r) * 18'(fiw_r);
            close_begin_r <= win_begin_r;
            close_len_r   <= win_len_r;
          end
          if (starts) begin
            win_begin_r <= sstart_r;
            win_time_r  <= tms_r;
            win_len_r   <= 64'(wl_r);
          end
        end
      end
      if (cmd.chan_err) begin
        act_r <= ACT_SKIP;
      end
      if (cmd.write && kind_r == KIND_TOT) begin
        tot_re_r <= acc ? sat40(41'($signed(tot_re_r)) + 41'($signed(re_r))) : 40'($signed(re_r));
        tot_im_r <= acc ? sat40(41'($signed(tot_im_r)) + 41'($signed(im_r))) : 40'($signed(im_r));
      end
      if (cmd.emit || cmd.chan_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chan_err) begin
      o_kind_r  <= '0;
      o_idx_r   <= '0;
      o_re_r    <= '0;
      o_im_r    <= '0;
      o_w_r     <= '0;
      o_start_r <= '0;
      o_len_r   <= '0;
      o_last_r  <= 1'b0;
      o_cherr_r <= 1'b1;
    end else if (cmd.emit) begin
      o_kind_r  <= kind_r;
      o_idx_r   <= idx_r;
      o_re_r    <= (kind_r == KIND_TOT) ? sat32(42'($signed(tot_re_r))) : res_re_r;
      o_im_r    <= (kind_r == KIND_TOT) ? sat32(42'($signed(tot_im_r))) :
                   (kind_r == KIND_VIS || kind_r == KIND_EVEC) ? res_im_r : 32'd0;
      o_w_r     <= (kind_r == KIND_VIS) ? res_w_r : 32'd0;
      o_start_r <= close_begin_r;
      o_len_r   <= close_len_r;
      o_last_r  <= last_r;
      o_cherr_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_kind      = o_kind_r;
  assign out_ch.out_index     = o_idx_r;
  assign out_ch.avg_re        = o_re_r;
  assign out_ch.avg_im        = o_im_r;
  assign out_ch.avg_weight    = o_w_r;
  assign out_ch.window_start  = o_start_r;
  assign out_ch.window_len    = o_len_r;
  assign out_ch.out_last      = o_last_r;
  assign out_ch.channel_error = o_cherr_r;

  assign sts.first    = first_r;
  assign sts.locked   = locked_r;
  assign sts.ch_mis   = ch_r != lock_ch_r;
  assign sts.act      = act_r;
  assign sts.item_ok  = item_ok;
  assign sts.kind     = kind_r;
  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;
  assign sts.out_free = out_free;
endmodule

/* rtl/wfa_ctrl.sv */
`timescale 1ns / 1ps
module wfa_ctrl import wfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wfa_sts_t sts,
  output wfa_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR   = 3'd1;
  localparam logic [2:0] S_CHERR = 3'd2;
  localparam logic [2:0] S_MODW  = 3'd3;
  localparam logic [2:0] S_SLOT  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_DIVW  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] op_r;
  logic [2:0] op_nxt;
  logic       closing;
  logic       update;
  logic [2:0] nop;

  assign closing = sts.act == ACT_CLOSE_START || sts.act == ACT_CLOSE_SKIP;
  assign update  = sts.act == ACT_START || sts.act == ACT_CLOSE_START || sts.act == ACT_ACC;
  assign nop     = next_op((state_r == S_RD) ? OP_NONE : op_r, sts.kind, closing, update);
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (!sts.first) begin
          state_nxt = S_SLOT;
        end else if (sts.locked && sts.ch_mis) begin
          state_nxt = S_CHERR;
        end else begin
          op_nxt        = OP_MOD;
          cmd.div_start = 1'b1;
          state_nxt     = S_MODW;
        end
      end
      S_CHERR: begin
        if (sts.out_free) begin
          cmd.chan_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MODW: begin
        if (sts.div_done) begin
          cmd.decide = 1'b1;
          state_nxt  = S_SLOT;
        end
      end
      S_SLOT: begin
        if (sts.act == ACT_SKIP || !sts.item_ok) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (nop == OP_NONE) begin
          state_nxt = S_FIN;
        end else begin
          op_nxt        = nop;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          if (nop == OP_NONE) begin
            state_nxt = S_FIN;
          end else begin
            op_nxt        = nop;
            cmd.div_start = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!closing || sts.out_free) begin
          cmd.emit  = closing;
          cmd.write = update;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.op = cmd.div_start ? op_nxt : op_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end
endmodule

/* rtl/windowed_frame_averager.sv */
`timescale 1ns / 1ps
// One word at a time; each divide runs on the shared radix-2 divider.
// The first word of a frame adds one alignment divide; a closing visibility word
// needs up to four more.
// Throughput: the next word is taken when the previous one has finished.
// Reset: synchronous active-low rst_n clears window state, config to defaults;
// accumulator memories are not cleared.
`include "windowed_frame_averager_macros.svh"
module windowed_frame_averager import wfa_pkg::*; #(
  parameter int N_PRODUCTS = 4096,
  parameter int NUM_ELEM = 2048,
  parameter int NUM_EV = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  wfa_in_if.sink    in_ch,
  wfa_out_if.source out_ch,
  wfa_cfg_if.sink   cfg_ch
);
  wfa_cmd_t cmd;
  wfa_sts_t sts;
  logic     in_rdy;

  assign in_ch.ready = in_rdy;

  wfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_rdy),
    .sts(sts), .cmd(cmd)
  );

  wfa_dp #(.N_PRODUCTS(N_PRODUCTS), .NUM_ELEM(NUM_ELEM), .NUM_EV(NUM_EV)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .cmd(cmd), .sts(sts)
  );

  `WFA_ASSERT_NOW(a_div_idle_start, clk, rst_n, cmd.div_start, !sts.div_busy)
  `WFA_ASSERT_NOW(a_cherr_zero, clk, rst_n, out_ch.valid && out_ch.channel_error,
                  out_ch.avg_re == 0 && out_ch.avg_weight == 0 && !out_ch.out_last)
  `WFA_ASSERT_NOW(a_weight_vis_only, clk, rst_n, out_ch.valid && out_ch.out_kind != KIND_VIS,
                  out_ch.avg_weight == 0)
  `WFA_ASSERT_NEXT(a_load_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule

/* tb/windowed_frame_averager_test.sv */
`timescale 1ns / 1ps
module windowed_frame_averager_test;
  import wfa_pkg::*;

  localparam int NPROD = 4096;
  localparam int NEV = 4;
  localparam int NELEM = 2048;
  localparam int EIG_N = NEV + NEV * NELEM + 1;
  localparam int LIMIT = 4000000;
  localparam int SETTLE = 400;
  localparam int FLEN = 100;
  localparam logic [15:0] CHAN = 16'd7;
  localparam int CHK_PRED = 0;
  localparam int CHK_NONE = 1;
  localparam int CHK_CHERR = 2;
  localparam int NPHASE = 4;

  typedef struct {
    logic [2:0]  kind;
    logic [12:0] index;
    logic        first;
    logic        last;
    logic [63:0] seq_start;
    logic [31:0] seq_length;
    logic [15:0] channel_id;
    logic [63:0] time_ms;
    logic [31:0] value_re;
    logic [31:0] value_im;
    logic [31:0] weight;
  } word_t;

  typedef struct {
    logic [2:0]  kind;
    logic [12:0] index;
    logic [31:0] re;
    logic [31:0] im;
    logic [31:0] w;
    logic [63:0] wstart;
    logic [63:0] wlen;
    logic        last;
    logic        cherr;
  } avg_t;

  typedef struct {
    word_t w;
    int    chk;
  } row_t;

  logic clk;
  logic rst_n;
  wfa_in_if in_ch();
  wfa_out_if out_ch();
  wfa_cfg_if cfg_ch();

  windowed_frame_averager uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // averager state as seen from outside
  logic [8:0]  ns;
  logic [31:0] age;
  bit          locked;
  logic [15:0] lk_ch;
  int          fiw;
  bit [63:0]   win_end, win_begin, win_time, lock_len, out_len, close_begin, close_len;
  int          close_n;
  logic [2:0]  act;
  longint      vre[NPROD];
  longint      vim[NPROD];
  bit [63:0]   var_sum[NPROD];
  longint      ere[EIG_N];
  longint      eim[EIG_N];
  longint      tre, tim;

  avg_t   pending_avgs[$];
  int     errors = 0;
  int     cycles = 0;
  int     words_sent = 0;
  int     avgs_checked = 0;
  int     hold = 0;
  bit     calm = 0;
  row_t   directed[$];

  function automatic longint sat40(longint x);
    if (x > 64'sd549755813887) return 64'sd549755813887;
    if (x < -64'sd549755813888) return -64'sd549755813888;
    return x;
  endfunction

  function automatic logic [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] avg_div(longint s, int n);
    if (n == 0) return 32'd0;
    return sat32(s / longint'(n));
  endfunction

  function automatic logic [31:0] comb_weight(int n, bit [63:0] s);
    bit [63:0] q;
    if (s == 0) return 32'hffffffff;
    q = (64'(n) * 64'(n) << 32) / s;
    return q > 64'hffffffff ? 32'hffffffff : q[31:0];
  endfunction

  task automatic predict_avg(input word_t d, output bit emits, output avg_t r);
    bit [63:0] wl;
    bit [63:0] inv;
    bit        pos0, closing, starting, acc;
    int        slot;
    longint    re, im;
    r = '{default: '0};
    emits = 0;
    slot = 0;
    re = $signed(d.value_re);
    im = $signed(d.value_im);
    if (d.first) begin
      if (!locked) begin
        wl = 64'(ns) * 64'(d.seq_length);
        if (d.seq_start % wl != 0) begin
          act = ACT_SKIP;
          return;
        end
        locked = 1;
        lk_ch = d.channel_id;
        lock_len = wl;
        win_end = d.seq_start + wl;
      end else if (d.channel_id != lk_ch) begin
        act = ACT_SKIP;
        emits = 1;
        r.cherr = 1;
        return;
      end
      pos0 = ((d.seq_start % lock_len) / 64'(d.seq_length)) == 0;
      if (fiw == 0) begin
        act = pos0 ? ACT_START : ACT_SKIP;
      end else if (d.seq_start < win_end) begin
        act = ACT_ACC;
        if (fiw < 511) fiw++;
      end else if (d.time_ms > win_time && d.time_ms - win_time > 64'(age)) begin
        fiw = 0;
        act = pos0 ? ACT_START : ACT_SKIP;
      end else begin
        close_n = fiw;
        close_begin = win_begin;
        close_len = out_len;
        fiw = 0;
        act = pos0 ? ACT_CLOSE_START : ACT_CLOSE_SKIP;
      end
      if (act == ACT_START || act == ACT_CLOSE_START) begin
        fiw = 1;
        win_end = d.seq_start + lock_len;
        win_begin = d.seq_start;
        win_time = d.time_ms;
        out_len = 64'(d.seq_length) * 64'(ns);
      end
    end
    if (act == ACT_SKIP) return;
    case (d.kind)
      KIND_VIS: begin
        if (d.index >= NPROD) return;
        slot = d.index;
      end
      KIND_EVAL: begin
        if (d.index >= NEV) return;
        slot = d.index;
      end
      KIND_EVEC: begin
        if (d.index >= NEV * NELEM) return;
        slot = NEV + d.index;
      end
      KIND_ERMS: slot = EIG_N - 1;
      KIND_TOT: slot = 0;
      default: return;
    endcase
    closing = act == ACT_CLOSE_START || act == ACT_CLOSE_SKIP;
    starting = act == ACT_START || act == ACT_CLOSE_START;
    acc = act == ACT_ACC;
    if (closing) begin
      emits = 1;
      r.kind = d.kind;
      r.index = d.index;
      if (d.kind == KIND_VIS) begin
        r.re = avg_div(vre[slot], close_n);
        r.im = avg_div(vim[slot], close_n);
        r.w = comb_weight(close_n, var_sum[slot]);
      end else if (d.kind == KIND_TOT) begin
        r.re = sat32(tre);
        r.im = sat32(tim);
      end else begin
        r.re = avg_div(ere[slot], close_n);
        r.im = d.kind == KIND_EVEC ? avg_div(eim[slot], close_n) : 32'd0;
      end
      r.wstart = close_begin;
      r.wlen = close_len;
      r.last = d.last;
    end
    if (starting || acc) begin
      if (d.kind == KIND_VIS) begin
        if (d.weight == 0) inv = 64'hffffffff;
        else inv = 64'h100000000 / 64'(d.weight);
        if (inv > 64'hffffffff) inv = 64'hffffffff;
        vre[slot] = acc ? sat40(vre[slot] + re) : re;
        vim[slot] = acc ? sat40(vim[slot] + im) : im;
        if (acc) begin
          inv += var_sum[slot];
          if (inv > 64'hffffffffffff) inv = 64'hffffffffffff;
        end
        var_sum[slot] = inv;
      end else if (d.kind == KIND_TOT) begin
        tre = acc ? sat40(tre + re) : re;
        tim = acc ? sat40(tim + im) : im;
      end else begin
        ere[slot] = acc ? sat40(ere[slot] + re) : re;
        eim[slot] = acc ? sat40(eim[slot] + im) : im;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input word_t d, input int chk);
    int   gap;
    bit   emits;
    avg_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= d.kind;
    in_ch.index <= d.index;
    in_ch.first_item <= d.first;
    in_ch.last_item <= d.last;
    in_ch.seq_start <= d.seq_start;
    in_ch.seq_length <= d.seq_length;
    in_ch.channel_id <= d.channel_id;
    in_ch.time_ms <= d.time_ms;
    in_ch.value_re <= d.value_re;
    in_ch.value_im <= d.value_im;
    in_ch.weight <= d.weight;
    do @(posedge clk); while (!in_ch.ready);
    predict_avg(d, emits, r);
    if (chk == CHK_CHERR) pending_avgs.push_back('{cherr: 1'b1, default: '0});
    else if (chk == CHK_PRED && emits) pending_avgs.push_back(r);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    in_ch.valid <= 1'b0;
    while (pending_avgs.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_NUM_SAMPLES) ns = data[8:0];
    else if (idx == REG_MAX_AGE) age = data;
  endtask

  function automatic word_t mk(logic [2:0] kind, logic [12:0] index, logic first, logic last,
                               logic [63:0] start, logic [31:0] len, logic [15:0] ch,
                               logic [63:0] tms, logic [31:0] re, logic [31:0] im,
                               logic [31:0] w);
    word_t d;
    d = '{kind, index, first, last, start, len, ch, tms, re, im, w};
    return d;
  endfunction

  function automatic logic [31:0] rand_val();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_weight();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd1;
    if (r == 2) return $urandom_range(2, 255);
    return $urandom;
  endfunction

  // one frame: fixed element layout so every read slot was written at window start
  task automatic send_frame(input logic [63:0] start, input logic [31:0] len,
                            input logic [15:0] ch, input logic [63:0] tms);
    logic [2:0]  lay_kind[6];
    logic [12:0] lay_idx[6];
    word_t       d;
    lay_kind = '{KIND_VIS, KIND_VIS, KIND_EVAL, KIND_EVEC, KIND_ERMS, KIND_TOT};
    lay_idx = '{13'd0, 13'd4095, 13'd0, 13'd8191, 13'($urandom), 13'($urandom)};
    for (int i = 0; i < 6; i++) begin
      if (i > 0 && $urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: d = mk(3'($urandom_range(5, 7)), 13'($urandom), 0, 0, start, len, ch, tms,
                    rand_val(), rand_val(), rand_weight());
          1: d = mk(KIND_VIS, 13'($urandom_range(NPROD, 8191)), 0, 0, start, len, ch, tms,
                    rand_val(), rand_val(), rand_weight());
          default: d = mk(KIND_EVAL, 13'($urandom_range(NEV, 8191)), 0, 0, start, len, ch,
                          tms, rand_val(), rand_val(), rand_weight());
        endcase
        send_word(d, CHK_PRED);
      end
      d = mk(lay_kind[i], lay_idx[i], i == 0, i == 5, start, len, ch, tms,
             rand_val(), rand_val(), rand_weight());
      send_word(d, CHK_PRED);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      $error("%s: expected %h, got %h", name, exp, got);
      errors++;
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("windowed_frame_averager verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold > 0) begin
      out_ch.ready <= 1'b0;
      hold--;
    end else if (calm || $urandom_range(99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      hold = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    avg_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_avgs.size() == 0) begin
        $error("averaged word with none expected");
        errors++;
      end else begin
        e = pending_avgs.pop_front();
        check_field("out_kind", e.kind, out_ch.out_kind);
        check_field("out_index", e.index, out_ch.out_index);
        check_field("avg_re", e.re, $unsigned(out_ch.avg_re));
        check_field("avg_im", e.im, $unsigned(out_ch.avg_im));
        check_field("avg_weight", e.w, out_ch.avg_weight);
        check_field("window_start", e.wstart, out_ch.window_start);
        check_field("window_len", e.wlen, out_ch.window_len);
        check_field("out_last", e.last, out_ch.out_last);
        check_field("channel_error", e.cherr, out_ch.channel_error);
        avgs_checked++;
      end
    end
  end

  initial begin
    logic [8:0]  ns_set[NPHASE];
    logic [31:0] age_set[NPHASE];
    logic [63:0] k, tms, start;
    logic [31:0] len;
    logic [15:0] ch;
    int          r;
    ns_set = '{9'd256, 9'd1, 9'd3, 9'd2};
    age_set = '{32'd0, 32'hffffffff, 32'd5, 32'd120000};
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.kind = 0;
    in_ch.index = 0;
    in_ch.first_item = 0;
    in_ch.last_item = 0;
    in_ch.seq_start = 0;
    in_ch.seq_length = 0;
    in_ch.channel_id = 0;
    in_ch.time_ms = 0;
    in_ch.value_re = 0;
    in_ch.value_im = 0;
    in_ch.weight = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.idx = 0;
    cfg_ch.data = 0;
    ns = NS_RESET;
    age = AGE_RESET;
    locked = 0;
    lk_ch = 0;
    fiw = 0;
    win_end = 0;
    win_begin = 0;
    win_time = 0;
    lock_len = 0;
    out_len = 0;
    close_n = 0;
    close_begin = 0;
    close_len = 0;
    act = ACT_SKIP;
    tre = 0;
    tim = 0;

    // before lock: all-ones header and a misaligned start are both skipped
    directed.push_back('{mk(KIND_VIS, 13'd0, 1, 1, '1, '1, '1, '1, 32'h7fffffff,
                            32'h80000000, '1), CHK_NONE});
    directed.push_back('{mk(3'd7, 13'd8191, 1, 1, 64'd150, FLEN, CHAN, 64'd1000, 0, 0, 0),
                         CHK_NONE});
    for (int f = 0; f < 2; f++) begin
      start = f * FLEN;
      tms = 1000 + 10 * f;
      directed.push_back('{mk(KIND_VIS, 13'd0, 1, 0, start, FLEN, CHAN, tms, 32'h7fffffff,
                              32'h80000000, f ? 32'hffffffff : 32'd0), CHK_PRED});
      directed.push_back('{mk(KIND_VIS, 13'd4095, 0, 0, start, FLEN, CHAN, tms, 32'h80000000,
                              32'h7fffffff, 32'd1), CHK_PRED});
      directed.push_back('{mk(KIND_EVAL, 13'd0, 0, 0, start, FLEN, CHAN, tms, 32'h7fffffff,
                              32'h7fffffff, 0), CHK_PRED});
      directed.push_back('{mk(KIND_EVEC, 13'd8191, 0, 0, start, FLEN, CHAN, tms, 32'h80000000,
                              32'h80000000, 0), CHK_PRED});
      directed.push_back('{mk(KIND_ERMS, 13'd0, 0, 0, start, FLEN, CHAN, tms, 32'h00012345,
                              0, 0), CHK_PRED});
      directed.push_back('{mk(KIND_TOT, 13'd8191, 0, 1, start, FLEN, CHAN, tms, 32'h7fffffff,
                              32'h7fffffff, 0), CHK_PRED});
    end
    directed.push_back('{mk(KIND_VIS, 13'd0, 1, 1, 64'd200, FLEN, 16'd8, 64'd1020, 1, 1, 1),
                         CHK_CHERR});
    directed.push_back('{mk(KIND_VIS, 13'd0, 1, 0, 64'd200, FLEN, CHAN, 64'd1020, 32'h10000,
                            32'hffff0000, 32'h10000), CHK_PRED});
    directed.push_back('{mk(KIND_VIS, 13'd4095, 0, 0, 64'd200, FLEN, CHAN, 64'd1020, 5, 7,
                            32'h20000), CHK_PRED});
    directed.push_back('{mk(KIND_EVAL, 13'd0, 0, 0, 64'd200, FLEN, CHAN, 64'd1020, 3, 0, 0),
                         CHK_PRED});
    directed.push_back('{mk(KIND_EVEC, 13'd8191, 0, 0, 64'd200, FLEN, CHAN, 64'd1020, 9, 9, 0),
                         CHK_PRED});
    directed.push_back('{mk(KIND_ERMS, 13'd17, 0, 0, 64'd200, FLEN, CHAN, 64'd1020, 1, 0, 0),
                         CHK_PRED});
    directed.push_back('{mk(KIND_TOT, 13'd0, 0, 1, 64'd200, FLEN, CHAN, 64'd1020, 2, 2, 0),
                         CHK_PRED});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i].w, directed[i].chk);

    k = 3;
    tms = 1020;
    for (int p = 0; p < NPHASE; p++) begin
      write_reg(REG_NUM_SAMPLES, 32'(ns_set[p]));
      write_reg(REG_MAX_AGE, age_set[p]);
      while (words_sent < 21 + (p + 1) * 470) begin
        if ($urandom_range(99) < 3) calm = !calm;
        start = k * FLEN;
        len = FLEN;
        ch = CHAN;
        tms += $urandom_range(0, 2);
        r = $urandom_range(99);
        if (r < 5) begin
          ch = CHAN + 16'($urandom_range(1, 65535));
        end else if (r < 10) begin
          start += $urandom_range(1, FLEN - 1);
        end else if (r < 14) begin
          tms += 64'(age) + $urandom_range(1, 1000);
        end else if (r < 18) begin
          k += $urandom_range(1, 4);
          start = k * FLEN;
        end else if (r < 21) begin
          start += $urandom_range(0, 3 * FLEN);
          len = $urandom_range(1, 32'hffffffff);
        end
        send_frame(start, len, ch, tms);
        k++;
      end
    end
    calm = 0;
    in_ch.valid <= 1'b0;
    while (pending_avgs.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d words over %0d register settings; %0d averaged words compared.",
             words_sent, NPHASE + 1, avgs_checked);
    if (errors == 0 && pending_avgs.size() == 0) begin
      $display("windowed_frame_averager verification clean");
    end else begin
      $display("windowed_frame_averager verification failed");
    end
    $finish;
  end

endmodule
